/* hw/rtl/csm_pkg.sv */
// Shared types and constants for the CSR sparse matrix-vector block.
// Holds op codes, field widths, default sizes and the result item struct.
// No dependencies.
`timescale 1ns / 1ps

package csm_pkg;

  // Field widths of the command and result items
  localparam int OP_W    = 3;
  localparam int IDX_W   = 12;
  localparam int VAL_W   = 32;
  localparam int ROW_W   = 16;
  localparam int SUM_W   = 64;

  // Default sizes
  localparam int VECTOR_DEPTH_DEF = 4096;
  localparam int ROW_LIMIT_DEF    = 65536;

  // Result queue: power of two depth
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Op codes
  localparam logic [OP_W-1:0] OP_LOAD    = 3'd0;
  localparam logic [OP_W-1:0] OP_NZ      = 3'd1;
  localparam logic [OP_W-1:0] OP_NZ_END  = 3'd2;
  localparam logic [OP_W-1:0] OP_END     = 3'd3;
  localparam logic [OP_W-1:0] OP_RESTART = 3'd4;

  // Saturation bounds of the Q32.32 accumulator
  localparam logic signed [SUM_W-1:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [SUM_W-1:0] SUM_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic [ROW_W-1:0]        row;
    logic signed [SUM_W-1:0] sum;
    logic                    saturated;
  } result_t;

endpackage

/* hw/rtl/csm_if.sv */
// Handshake channels of the CSR sparse matrix-vector block.
// csm_cmd_if carries command items, csm_res_if carries result items.
// Depends on csm_pkg.
`timescale 1ns / 1ps

interface csm_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [csm_pkg::OP_W-1:0]         op;
  logic [csm_pkg::IDX_W-1:0]        index;
  logic signed [csm_pkg::VAL_W-1:0] value;

  modport source (output valid, output op, output index, output value, input ready);
  modport sink   (input valid, input op, input index, input value, output ready);
endinterface

interface csm_res_if;
  logic                             valid;
  logic                             ready;
  logic [csm_pkg::ROW_W-1:0]        row;
  logic signed [csm_pkg::SUM_W-1:0] sum;
  logic                             saturated;

  modport source (output valid, output row, output sum, output saturated, input ready);
  modport sink   (input valid, input row, input sum, input saturated, output ready);
endinterface

/* hw/rtl/csr_sparse_matvec.sv */
// Top level of the CSR sparse matrix-vector block: vector store, multiplier,
// saturating row accumulator and result queue.
// Depends on csm_pkg, csm_cmd_if, csm_res_if and csm_result_queue.
//
//   channel | dir | modport | payload
//   --------+-----+---------+---------------------------------------------
//   cmd     | in  | sink    | op (3), index (12), value (32, signed Q16.16)
//   res     | out | source  | row (16), sum (64, signed Q32.32), saturated
//
// One item is taken every cycle while the result queue has room; the rate is
// set by the single-port vector store read and the one 32x32 multiplier.
// A result item reaches res from its accepted command item through the store
// read, the multiply and the accumulate into the queue. The store is
// written and read in the accept cycle, so a load followed at once by a
// nonzero on the same column sees the new entry. cmd.ready comes from
// registers only: it is high while queued results plus items in flight stay
// below the queue depth, so a stalled res channel never drops a result.
// Synchronous reset clears the pipeline, the accumulator, the row count and
// the queue; the store keeps its contents and needs no clearing pass.
`timescale 1ns / 1ps

module csr_sparse_matvec #(
  parameter int VECTOR_DEPTH = csm_pkg::VECTOR_DEPTH_DEF,
  parameter int ROW_LIMIT    = csm_pkg::ROW_LIMIT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  csm_cmd_if.sink   cmd,
  csm_res_if.source res
);

  localparam int AW = $clog2(VECTOR_DEPTH);
  localparam int RW = $clog2(ROW_LIMIT);

  // Vector store
  logic signed [csm_pkg::VAL_W-1:0] store [VECTOR_DEPTH];
  logic signed [csm_pkg::VAL_W-1:0] rdata;

  logic        accept;
  logic [31:0] idx_wide;
  logic        in_range;
  logic [AW-1:0] addr;

  // Stage 1: store data arrives
  logic                             s1_valid;
  logic [csm_pkg::OP_W-1:0]         s1_op;
  logic signed [csm_pkg::VAL_W-1:0] s1_value;
  logic                             s1_zero;
  logic signed [csm_pkg::VAL_W-1:0] x_op;
  logic signed [csm_pkg::SUM_W-1:0] prod_c;

  // Stage 2: product registered, accumulate
  logic                             s2_valid;
  logic [csm_pkg::OP_W-1:0]         s2_op;
  logic signed [csm_pkg::SUM_W-1:0] s2_prod;

  // Row state
  logic signed [csm_pkg::SUM_W-1:0] row_acc;
  logic                             overflow_seen;
  logic [RW-1:0]                    row_counter;
  logic [RW-1:0]                    row_counter_next;
  logic [31:0]                      row_wide;

  logic [csm_pkg::SUM_W:0]          sum_ext;
  logic                             add_ovf;
  logic signed [csm_pkg::SUM_W-1:0] acc_add;

  logic                             push;
  csm_pkg::result_t                 push_item;
  logic [csm_pkg::QCNT_W-1:0]       q_count;
  logic [csm_pkg::QCNT_W-1:0]       committed;

  // Hold ready low once every queue slot is spoken for
  assign committed = q_count + csm_pkg::QCNT_W'(s1_valid) + csm_pkg::QCNT_W'(s2_valid);
  assign cmd.ready = (committed < csm_pkg::QCNT_W'(csm_pkg::QUEUE_DEPTH));
  assign accept    = cmd.valid && cmd.ready;

  assign idx_wide = 32'(cmd.index);
  assign in_range = (idx_wide < 32'(VECTOR_DEPTH));
  assign addr     = idx_wide[AW-1:0];

  // Store write on load, read on every item (data used only by nonzeros)
  always_ff @(posedge clk) begin
    if (accept && cmd.op == csm_pkg::OP_LOAD && in_range) begin
      store[addr] <= cmd.value;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata <= store[addr];
    end
  end

  // Pipeline registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op    <= cmd.op;
      s1_value <= cmd.value;
      s1_zero  <= !in_range;
    end
    s2_op   <= s1_op;
    s2_prod <= prod_c;
  end

  // Exact Q16.16 x Q16.16 product; an out-of-range column multiplies by zero
  assign x_op   = s1_zero ? '0 : rdata;
  assign prod_c = s1_value * x_op;

  // Saturating add of the product to the running row sum
  assign sum_ext = {row_acc[csm_pkg::SUM_W-1], row_acc}
                 + {s2_prod[csm_pkg::SUM_W-1], s2_prod};
  assign add_ovf = sum_ext[csm_pkg::SUM_W] != sum_ext[csm_pkg::SUM_W-1];
  assign acc_add = !add_ovf ? sum_ext[csm_pkg::SUM_W-1:0] :
                   (sum_ext[csm_pkg::SUM_W] ? csm_pkg::SUM_MIN : csm_pkg::SUM_MAX);

  // Advance the row count, wrapping at ROW_LIMIT
  assign row_counter_next = (row_counter == RW'(ROW_LIMIT - 1)) ? '0 : row_counter + 1'b1;
  assign row_wide         = 32'(row_counter);

  always_comb begin
    push           = 1'b0;
    push_item.row  = row_wide[csm_pkg::ROW_W-1:0];
    push_item.sum  = row_acc;
    push_item.saturated = overflow_seen;
    if (s2_valid) begin
      case (s2_op)
        csm_pkg::OP_NZ_END: begin
          push                = 1'b1;
          push_item.sum       = acc_add;
          push_item.saturated = overflow_seen || add_ovf;
        end
        csm_pkg::OP_END: begin
          push = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_acc       <= '0;
      overflow_seen <= 1'b0;
      row_counter   <= '0;
    end else if (s2_valid) begin
      case (s2_op)
        csm_pkg::OP_NZ: begin
          row_acc       <= acc_add;
          overflow_seen <= overflow_seen || add_ovf;
        end
        csm_pkg::OP_NZ_END, csm_pkg::OP_END: begin
          row_acc       <= '0;
          overflow_seen <= 1'b0;
          row_counter   <= row_counter_next;
        end
        csm_pkg::OP_RESTART: begin
          row_acc       <= '0;
          overflow_seen <= 1'b0;
          row_counter   <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  csm_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .count     (q_count),
    .res       (res)
  );

`ifndef ASSERT_OFF
  // Items in flight plus queued results never exceed the queue
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    committed <= csm_pkg::QCNT_W'(csm_pkg::QUEUE_DEPTH))
    else $error("result queue overrun");

  // A row close always lands in the queue
  a_close_push: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && (s2_op == csm_pkg::OP_NZ_END || s2_op == csm_pkg::OP_END))
      |=> (q_count != '0))
    else $error("closed row did not reach the queue");

  // Restart zeroes the row count and the accumulator
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_op == csm_pkg::OP_RESTART) |=> (row_counter == '0 && row_acc == '0))
    else $error("restart left row state behind");

  // Saturation on a mid-row nonzero is remembered
  a_sat_sticky: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_op == csm_pkg::OP_NZ && add_ovf) |=> overflow_seen)
    else $error("saturation flag lost");
`endif

endmodule

/* hw/rtl/csm_result_queue.sv */
// Small result queue that decouples the accumulator from the output channel.
// Holds up to csm_pkg::QUEUE_DEPTH result items and reports its fill count.
// Depends on csm_pkg and csm_res_if.
`timescale 1ns / 1ps

module csm_result_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  csm_pkg::result_t           push_item,
  output logic [csm_pkg::QCNT_W-1:0] count,
  csm_res_if.source                  res
);

  csm_pkg::result_t                entries [csm_pkg::QUEUE_DEPTH];
  logic [csm_pkg::QPTR_W-1:0]      wr_ptr;
  logic [csm_pkg::QPTR_W-1:0]      rd_ptr;
  logic                            pop;
  csm_pkg::result_t                head;

  assign pop       = res.valid && res.ready;
  assign head      = entries[rd_ptr];
  assign res.valid = (count != '0);
  assign res.row       = head.row;
  assign res.sum       = head.sum;
  assign res.saturated = head.saturated;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* tb/sv/tb.sv */
// Self-checking bench for csr_sparse_matvec: directed and random command items,
// a row-sum predictor, and handshake-level checking of every result item.
// Depends on csm_pkg, csm_cmd_if, csm_res_if and the block's RTL.
`timescale 1ns / 1ps

module tb;

  // Ops the block must ignore
  localparam logic [csm_pkg::OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [csm_pkg::OP_W-1:0] OP_UNUSED_MID   = 3'd6;
  localparam logic [csm_pkg::OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

  localparam logic [csm_pkg::IDX_W-1:0] IDX_TOP = '1;
  localparam int RANDOM_ITEMS  = 1400;
  localparam int DRAIN_EVERY   = 350;   // random items between full drains
  localparam int HOLD_AT       = 300;   // accepted items before the long sink hold
  localparam int LONG_HOLD     = 400;   // cycles of the long sink hold
  localparam int TAIL_CYCLES   = 20;    // quiet cycles after the last result

  typedef struct {
    logic [csm_pkg::OP_W-1:0]         op;
    logic [csm_pkg::IDX_W-1:0]        index;
    logic signed [csm_pkg::VAL_W-1:0] value;
    int                               gap;     // idle cycles before the item is offered
    bit                               drain;   // wait for every row sum before offering
  } cmd_item_t;

  logic clk;
  logic rst;

  csm_cmd_if cmd_ch ();
  csm_res_if res_ch ();

  csr_sparse_matvec u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  // Stimulus store and generation state
  cmd_item_t                 pend_q[$];
  cmd_item_t                 in_flight;
  logic [csm_pkg::IDX_W-1:0] loaded_cols[$];
  bit                        loaded_map[csm_pkg::VECTOR_DEPTH_DEF];
  bit                        calm_sender;
  bit                        drain_next;
  int                        useful_items;
  int                        total_items;

  // Predictor state: a private copy of the store, accumulator and row count
  logic signed [csm_pkg::VAL_W-1:0] vec_mirror[csm_pkg::VECTOR_DEPTH_DEF];
  logic signed [csm_pkg::SUM_W-1:0] row_acc;
  bit                               row_sat;
  int unsigned                      row_count;
  csm_pkg::result_t                 row_sums_q[$];

  // Progress counters; the NBA-updated ones are safe to read from other blocks
  int items_taken;
  int results_predicted;
  int results_checked;
  int fault_count;

  // Sink side
  int rx_pause;
  bit long_hold_done;

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Gap and value pickers
  // ---------------------------------------------------------------------------
  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 70) return $urandom_range(2, 1);
    if (r < 95) return $urandom_range(8, 3);
    return $urandom_range(60, 20);
  endfunction

  // Calm stretches give back-to-back items; otherwise a third of items wait.
  function automatic int sender_gap();
    if (calm_sender || $urandom_range(2, 0) != 0) return 0;
    return pick_gap();
  endfunction

  // Q16.16 operands: full range, small magnitudes, or the corners.
  function automatic logic [csm_pkg::VAL_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 40) return $urandom;
    if (r < 80) return $urandom_range(32'h0020_0000, 0) - 32'h0010_0000;
    case ($urandom_range(4, 0))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0001;
      default: return '0;
    endcase
  endfunction

  // Any index, for loads and for items that ignore it
  function automatic logic [csm_pkg::IDX_W-1:0] pick_idx();
    return csm_pkg::IDX_W'($urandom_range(IDX_TOP, 0));
  endfunction

  // Only columns that a load has already filled may be read.
  function automatic logic [csm_pkg::IDX_W-1:0] pick_col();
    return loaded_cols[$urandom_range(loaded_cols.size() - 1, 0)];
  endfunction

  task automatic push_cmd(input logic [csm_pkg::OP_W-1:0] op,
                          input logic [csm_pkg::IDX_W-1:0] index,
                          input logic [csm_pkg::VAL_W-1:0] value);
    cmd_item_t it;
    it.op    = op;
    it.index = index;
    it.value = value;
    it.gap   = sender_gap();
    it.drain = drain_next;
    drain_next = 1'b0;
    if (op == csm_pkg::OP_LOAD && !loaded_map[index]) begin
      loaded_map[index] = 1'b1;
      loaded_cols.push_back(index);
    end
    if (op <= csm_pkg::OP_RESTART) useful_items++;
    pend_q.push_back(it);
  endtask

  // ---------------------------------------------------------------------------
  // Row-sum predictor
  // ---------------------------------------------------------------------------
  // Emit the row index and its sum, then clear for the next row.
  task automatic close_row();
    csm_pkg::result_t r;
    r.row       = row_count[csm_pkg::ROW_W-1:0];
    r.sum       = row_acc;
    r.saturated = row_sat;
    row_sums_q.push_back(r);
    results_predicted++;
    row_acc   = '0;
    row_sat   = 1'b0;
    row_count = (row_count + 1) % csm_pkg::ROW_LIMIT_DEF;
  endtask

  task automatic predict_item(input cmd_item_t it);
    logic signed [csm_pkg::SUM_W-1:0] lhs;
    logic signed [csm_pkg::SUM_W-1:0] rhs;
    logic signed [csm_pkg::SUM_W-1:0] prod;
    logic [csm_pkg::SUM_W:0]          wide;
    case (it.op)
      csm_pkg::OP_LOAD: begin
        if (it.index < csm_pkg::VECTOR_DEPTH_DEF) vec_mirror[it.index] = it.value;
      end
      csm_pkg::OP_NZ, csm_pkg::OP_NZ_END: begin
        lhs = it.value;
        if (it.index < csm_pkg::VECTOR_DEPTH_DEF) rhs = vec_mirror[it.index];
        else rhs = '0;
        // Exact Q32.32 product, then one guard bit to spot overflow of the add
        prod = lhs * rhs;
        wide = {row_acc[csm_pkg::SUM_W-1], row_acc} + {prod[csm_pkg::SUM_W-1], prod};
        if (wide[csm_pkg::SUM_W] != wide[csm_pkg::SUM_W-1]) begin
          row_acc = wide[csm_pkg::SUM_W] ? csm_pkg::SUM_MIN : csm_pkg::SUM_MAX;
          row_sat = 1'b1;
        end else begin
          row_acc = wide[csm_pkg::SUM_W-1:0];
        end
        if (it.op == csm_pkg::OP_NZ_END) close_row();
      end
      csm_pkg::OP_END: close_row();
      csm_pkg::OP_RESTART: begin
        row_count = 0;
        row_acc   = '0;
        row_sat   = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer queued items, predict each one as it is accepted
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid      <= 1'b0;
      cmd_ch.op         <= csm_pkg::OP_LOAD;
      cmd_ch.index      <= '0;
      cmd_ch.value      <= '0;
      items_taken       <= 0;
      row_acc           = '0;
      row_sat           = 1'b0;
      row_count         = 0;
      results_predicted = 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        predict_item(in_flight);
        items_taken <= items_taken + 1;
      end
      // The slot is free once the current item has gone or none was offered
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (pend_q.size() == 0) begin
          cmd_ch.valid <= 1'b0;
        end else if (pend_q[0].drain && results_checked != results_predicted) begin
          // Hold until the sink has taken every row sum owed
          cmd_ch.valid <= 1'b0;
        end else if (pend_q[0].gap != 0) begin
          pend_q[0].gap = pend_q[0].gap - 1;
          cmd_ch.valid <= 1'b0;
        end else begin
          in_flight = pend_q.pop_front();
          cmd_ch.valid <= 1'b1;
          cmd_ch.op    <= in_flight.op;
          cmd_ch.index <= in_flight.index;
          cmd_ch.value <= in_flight.value;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sink readiness: random stalls, plus one long hold so the block backs up
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready   <= 1'b0;
      rx_pause       = 0;
      long_hold_done = 1'b0;
    end else if (!long_hold_done && items_taken >= HOLD_AT) begin
      long_hold_done = 1'b1;
      rx_pause       = LONG_HOLD;
      res_ch.ready   <= 1'b0;
    end else if (rx_pause != 0) begin
      rx_pause     = rx_pause - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
      if ($urandom_range(7, 0) == 0) rx_pause = pick_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each accepted row sum with the oldest one predicted
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    csm_pkg::result_t want;
    if (rst) begin
      results_checked <= 0;
      fault_count     = 0;
    end else if (res_ch.valid && res_ch.ready) begin
      if (row_sums_q.size() == 0) begin
        note_fault($sformatf("unexpected result: row %0d sum %h sat %b",
                             res_ch.row, res_ch.sum, res_ch.saturated));
      end else begin
        want = row_sums_q.pop_front();
        results_checked <= results_checked + 1;
        if (res_ch.row !== want.row)
          note_fault($sformatf("row index: expected %0d, got %0d", want.row, res_ch.row));
        if (res_ch.sum !== want.sum)
          note_fault($sformatf("row %0d sum: expected %h, got %h",
                               want.row, want.sum, res_ch.sum));
        if (res_ch.saturated !== want.saturated)
          note_fault($sformatf("row %0d saturation flag: expected %b, got %b",
                               want.row, want.saturated, res_ch.saturated));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned r;
    int          k;
    int          next_drain;
    rst               = 1'b1;
    useful_items      = 0;
    calm_sender       = 1'b0;
    drain_next        = 1'b0;

    // Directed: fill the corners of the store first
    push_cmd(csm_pkg::OP_LOAD, 12'd0, 32'h8000_0000);    // most negative entry
    push_cmd(csm_pkg::OP_LOAD, IDX_TOP, 32'h7FFF_FFFF);  // top index, most positive
    push_cmd(csm_pkg::OP_LOAD, 12'd1, 32'h0001_0000);    // 1.0
    push_cmd(csm_pkg::OP_LOAD, 12'd2, 32'h0000_0000);
    // Empty row closes with a zero sum
    push_cmd(csm_pkg::OP_END, 12'd0, 32'h0);
    // Two min*min products overflow upwards: clamp high and flag
    push_cmd(csm_pkg::OP_NZ, 12'd0, 32'h8000_0000);
    push_cmd(csm_pkg::OP_NZ_END, 12'd0, 32'h8000_0000);
    // Saturate, then carry on downwards from the clamped value
    push_cmd(csm_pkg::OP_NZ, 12'd0, 32'h8000_0000);
    push_cmd(csm_pkg::OP_NZ, 12'd0, 32'h8000_0000);
    push_cmd(csm_pkg::OP_NZ, IDX_TOP, 32'h8000_0000);
    push_cmd(csm_pkg::OP_NZ_END, 12'd1, 32'h7FFF_FFFF);
    // Three large negative products clamp low; a zero entry closes the row
    push_cmd(csm_pkg::OP_NZ, IDX_TOP, 32'h8000_0000);
    push_cmd(csm_pkg::OP_NZ, IDX_TOP, 32'h8000_0000);
    push_cmd(csm_pkg::OP_NZ, IDX_TOP, 32'h8000_0000);
    push_cmd(csm_pkg::OP_NZ_END, 12'd2, 32'h0000_0005);
    // Flag must be clear again on the following row
    push_cmd(csm_pkg::OP_NZ_END, 12'd1, 32'h0002_0000);
    // Restart in the middle of a row drops the partial sum and the row count
    push_cmd(csm_pkg::OP_NZ, 12'd0, 32'h7FFF_FFFF);
    push_cmd(csm_pkg::OP_RESTART, IDX_TOP, 32'hFFFF_FFFF);
    push_cmd(csm_pkg::OP_END, 12'd0, 32'h0);
    // Spare op codes do nothing
    push_cmd(OP_UNUSED_FIRST, 12'd0, 32'h8000_0000);
    push_cmd(OP_UNUSED_MID, 12'd1, 32'h0001_0000);
    push_cmd(OP_UNUSED_LAST, IDX_TOP, 32'hFFFF_FFFF);
    // Load and use the same column back to back: -1.0 * -1.0
    push_cmd(csm_pkg::OP_LOAD, 12'd3, 32'hFFFF_0000);
    push_cmd(csm_pkg::OP_NZ_END, 12'd3, 32'hFFFF_0000);

    // Random: mostly well-formed rows over loaded columns, some noise
    next_drain = useful_items + DRAIN_EVERY;
    while (useful_items < RANDOM_ITEMS + 24) begin
      calm_sender = ($urandom_range(3, 0) == 0);
      if (useful_items >= next_drain) begin
        drain_next = 1'b1;
        next_drain = next_drain + DRAIN_EVERY;
      end
      r = $urandom_range(99, 0);
      if (r < 12) begin
        k = $urandom_range(6, 1);
        repeat (k) push_cmd(csm_pkg::OP_LOAD, pick_idx(), pick_value());
      end else if (r < 82) begin
        // Mostly short rows, now and then a long one
        k = ($urandom_range(9, 0) == 0) ? $urandom_range(16, 7) : $urandom_range(5, 0);
        if (k == 0) begin
          push_cmd(csm_pkg::OP_END, pick_idx(), $urandom);
        end else begin
          repeat (k - 1) push_cmd(csm_pkg::OP_NZ, pick_col(), pick_value());
          if ($urandom_range(4, 0) == 0) begin
            push_cmd(csm_pkg::OP_NZ, pick_col(), pick_value());
            push_cmd(csm_pkg::OP_END, pick_idx(), $urandom);
          end else begin
            push_cmd(csm_pkg::OP_NZ_END, pick_col(), pick_value());
          end
        end
      end else if (r < 88) begin
        // Broken row: a few nonzeros thrown away by a restart
        k = $urandom_range(3, 0);
        repeat (k) push_cmd(csm_pkg::OP_NZ, pick_col(), pick_value());
        push_cmd(csm_pkg::OP_RESTART, pick_idx(), $urandom);
      end else if (r < 93) begin
        push_cmd(csm_pkg::OP_W'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST)),
                 pick_idx(), $urandom);
      end else begin
        // Stray nonzeros that run on into whatever row follows
        k = $urandom_range(3, 1);
        repeat (k) push_cmd(csm_pkg::OP_NZ, pick_col(), pick_value());
      end
    end

    // Drain, then close a few rows back to back
    calm_sender = 1'b1;
    drain_next  = 1'b1;
    repeat (4) push_cmd(csm_pkg::OP_END, pick_idx(), $urandom);

    total_items = pend_q.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Wait for the last item and the last row sum, then let the pipe settle
    do @(posedge clk);
    while (items_taken != total_items || results_checked != results_predicted);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fault_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/csm_pkg.sv
hw/rtl/csm_if.sv
hw/rtl/csm_result_queue.sv
hw/rtl/csr_sparse_matvec.sv
tb/sv/tb.sv
